[src/lswb_pkg.sv]
// lswb_pkg: request/result structs, result kind codes and constants
// for the LRU sector write buffer. No dependencies.
`default_nettype none
package lswb_pkg;

  localparam int PAGE_SECTORS = 8;
  localparam int PAGE_BITS    = 24;
  localparam int SEC_CW       = $clog2(PAGE_SECTORS + 1);
  localparam int SEC_IW       = (PAGE_SECTORS > 1) ? $clog2(PAGE_SECTORS) : 1;

  localparam logic [23:0] PAGE_MASK = 24'(((64'd1 << PAGE_BITS) - 64'd1) & 64'hffffffff);
  localparam logic [7:0]  SECT_ALL  = 8'(~(32'hffffffff << PAGE_SECTORS));

  localparam logic [1:0] KIND_WB    = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WDONE = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [23:0] page_number;
    logic [7:0]  sector_mask;
  } lswb_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] out_page;
    logic [7:0]  out_mask;
    logic [3:0]  hit_count;
    logic        last;
  } lswb_res_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[src/lswb_out_reg.sv]
// lswb_out_reg: result output register with valid/stall handshake.
// Depends on lswb_pkg for the result struct.
`default_nettype none
module lswb_out_reg
  import lswb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      ld,
  input  wire lswb_res_t ld_res,
  input  wire logic      out_stall,
  output logic           out_valid,
  output lswb_res_t      out_res,
  output logic           free
);

  logic      valid_r;
  lswb_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= ld_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign free      = !valid_r || !out_stall;

endmodule
`default_nettype wire

[src/lru_sector_write_buffer.sv]
// lru_sector_write_buffer: page write cache with sector bitmaps and LRU list.
// Depends on lswb_pkg and lswb_out_reg.
//
// One request is handled at a time. Every request first scans the tag store,
// one entry per cycle through its single read port. The scan is followed, as
// the request needs them, by an LRU move (skipped when the page is already at
// the head), evictions, slot choice and insert for a new page, or the sector
// walk for a present write; each write-back and the final result wait while
// the result side stalls. A read gives one result; a write gives up to eight
// write-backs and then a write-done result. Entry valid bits are flip-flops
// cleared by reset, so no clearing pass is needed.
`default_nettype none
module lru_sector_write_buffer
  import lswb_pkg::*;
#(
  parameter int BUFFER_ENTRIES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire lswb_req_t  in_req,
  output logic            out_valid,
  input  wire logic       out_stall,
  output lswb_res_t       out_res,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(BUFFER_ENTRIES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int HELD_W = $clog2(BUFFER_ENTRIES * PAGE_SECTORS + 1);
  localparam int CMP_W  = (HELD_W > 9) ? HELD_W : 9;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_EVLOOP  = 4'd3;
  localparam logic [3:0] S_SLOT    = 4'd4;
  localparam logic [3:0] S_INSERT  = 4'd5;
  localparam logic [3:0] S_SEC     = 4'd6;
  localparam logic [3:0] S_SEC_VRD = 4'd7;
  localparam logic [3:0] S_SEC_VIC = 4'd8;
  localparam logic [3:0] S_SEC_ADD = 4'd9;
  localparam logic [3:0] S_EV_RD   = 4'd10;
  localparam logic [3:0] S_EV_EMIT = 4'd11;
  localparam logic [3:0] S_MV_RD   = 4'd12;
  localparam logic [3:0] S_MV_UNL  = 4'd13;
  localparam logic [3:0] S_MV_PUSH = 4'd14;
  localparam logic [3:0] S_FINAL   = 4'd15;

  logic [3:0]                state_r, state_nxt, ret_r, ret_nxt;
  logic [8:0]                max_r;
  logic [BUFFER_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt, tail_r, tail_nxt;
  logic                      empty_r, empty_nxt;
  logic [HELD_W-1:0]         held_r, held_nxt;

  logic                      wr_r, wr_nxt;
  logic [23:0]               page_r, page_nxt;
  logic [7:0]                req_r, req_nxt;
  logic [CNT_W-1:0]          scan_r, scan_nxt;
  logic                      chk_r, chk_nxt;
  logic [IDX_W-1:0]          sidx_r, sidx_nxt;
  logic                      found_r, found_nxt;
  logic [IDX_W-1:0]          slot_r, slot_nxt;
  logic                      have_free_r, have_free_nxt;
  logic [IDX_W-1:0]          free_r, free_nxt;
  logic [7:0]                cur_bits_r, cur_bits_nxt;
  logic [3:0]                hits_r, hits_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [3:0]                need_r, need_nxt;
  logic [SEC_CW-1:0]         sec_r, sec_nxt;
  logic [IDX_W-1:0]          victim_r, victim_nxt;
  logic [1:0]                fin_kind_r, fin_kind_nxt;
  logic [7:0]                fin_mask_r, fin_mask_nxt;

  logic [23:0]      tag_mem  [BUFFER_ENTRIES];
  logic [7:0]       bits_mem [BUFFER_ENTRIES];
  logic [IDX_W-1:0] old_mem  [BUFFER_ENTRIES];
  logic [IDX_W-1:0] new_mem  [BUFFER_ENTRIES];
  logic [23:0]      tag_q;
  logic [7:0]       bits_q;
  logic [IDX_W-1:0] old_q, new_q;

  logic [IDX_W-1:0] rd_addr;
  logic             tag_we, bits_we, old_we, new_we;
  logic [7:0]       bits_wd;
  logic [IDX_W-1:0] old_wa, old_wd, new_wa, new_wd;

  logic             unl_go, psh_go;
  logic [IDX_W-1:0] unl_s;
  logic             ld, out_free;
  lswb_res_t        ld_res;

  logic [7:0]       st, bit_sel;
  logic [3:0]       pc, sz;
  logic [CMP_W-1:0] avail;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    valid_nxt     = valid_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    held_nxt      = held_r;
    wr_nxt        = wr_r;
    page_nxt      = page_r;
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    sidx_nxt      = sidx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    have_free_nxt = have_free_r;
    free_nxt      = free_r;
    cur_bits_nxt  = cur_bits_r;
    hits_nxt      = hits_r;
    cnt_nxt       = cnt_r;
    need_nxt      = need_r;
    sec_nxt       = sec_r;
    victim_nxt    = victim_r;
    fin_kind_nxt  = fin_kind_r;
    fin_mask_nxt  = fin_mask_r;
    rd_addr       = slot_r;
    tag_we        = 1'b0;
    bits_we       = 1'b0;
    bits_wd       = cur_bits_r;
    old_we        = 1'b0;
    old_wa        = slot_r;
    old_wd        = head_r;
    new_we        = 1'b0;
    new_wa        = head_r;
    new_wd        = slot_r;
    unl_go        = 1'b0;
    unl_s         = slot_r;
    psh_go        = 1'b0;
    ld            = 1'b0;
    ld_res        = '0;
    st            = found_r ? cur_bits_r : 8'd0;
    pc            = pop8(req_r);
    sz            = pop8(bits_q);
    bit_sel       = 8'd1 << sec_r[SEC_IW-1:0];
    avail         = (CMP_W'(max_r) > CMP_W'(held_r)) ?
                    CMP_W'(max_r) - CMP_W'(held_r) : '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wr_nxt        = in_req.req_type;
          page_nxt      = in_req.page_number & PAGE_MASK;
          req_nxt       = in_req.sector_mask & SECT_ALL;
          scan_nxt      = '0;
          chk_nxt       = 1'b0;
          found_nxt     = 1'b0;
          have_free_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr  = scan_r[IDX_W-1:0];
        sidx_nxt = scan_r[IDX_W-1:0];
        chk_nxt  = (scan_r != CNT_W'(BUFFER_ENTRIES));
        if (chk_r) begin
          if (valid_r[sidx_r] && tag_q == page_r && !found_r) begin
            found_nxt    = 1'b1;
            slot_nxt     = sidx_r;
            cur_bits_nxt = bits_q;
          end
          if (!valid_r[sidx_r] && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = sidx_r;
          end
        end
        if (scan_r == CNT_W'(BUFFER_ENTRIES)) begin
          state_nxt = S_DECIDE;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        hits_nxt     = 4'd0;
        fin_kind_nxt = KIND_WDONE;
        fin_mask_nxt = 8'd0;
        if (!wr_r) begin
          hits_nxt     = pop8(req_r & st);
          fin_kind_nxt = KIND_READ;
          fin_mask_nxt = req_r & ~st;
          ret_nxt      = S_FINAL;
          state_nxt    = (found_r && pop8(req_r & st) != 4'd0) ? S_MV_RD : S_FINAL;
        end else if (req_r == 8'd0) begin
          state_nxt = S_FINAL;
        end else if (!found_r) begin
          cnt_nxt   = pc;
          need_nxt  = (CMP_W'(pc) > avail) ? 4'(CMP_W'(pc) - avail) : 4'd0;
          state_nxt = S_EVLOOP;
        end else begin
          sec_nxt   = '0;
          state_nxt = S_SEC;
        end
      end
      S_EVLOOP: begin
        if (need_r != 4'd0 && !empty_r) begin
          victim_nxt = tail_r;
          ret_nxt    = S_EVLOOP;
          state_nxt  = S_EV_RD;
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (have_free_r) begin
          slot_nxt  = free_r;
          state_nxt = S_INSERT;
        end else begin
          victim_nxt = tail_r;
          slot_nxt   = tail_r;
          ret_nxt    = S_INSERT;
          state_nxt  = S_EV_RD;
        end
      end
      S_INSERT: begin
        valid_nxt[slot_r] = 1'b1;
        tag_we            = 1'b1;
        bits_we           = 1'b1;
        bits_wd           = req_r;
        psh_go            = 1'b1;
        held_nxt          = held_r + HELD_W'(cnt_r);
        state_nxt         = S_FINAL;
      end
      S_SEC: begin
        if (sec_r == SEC_CW'(PAGE_SECTORS)) begin
          bits_we   = 1'b1;
          state_nxt = S_FINAL;
        end else if ((req_r & bit_sel) == 8'd0) begin
          sec_nxt = sec_r + SEC_CW'(1);
        end else if ((cur_bits_r & bit_sel) != 8'd0) begin
          hits_nxt  = hits_r + 4'd1;
          sec_nxt   = sec_r + SEC_CW'(1);
          ret_nxt   = S_SEC;
          state_nxt = S_MV_RD;
        end else if (CMP_W'(held_r) >= CMP_W'(max_r) &&
                     !(head_r == slot_r && tail_r == slot_r)) begin
          state_nxt = S_SEC_VRD;
        end else begin
          state_nxt = S_SEC_ADD;
        end
      end
      S_SEC_VRD: begin
        state_nxt = S_SEC_VIC;
      end
      S_SEC_VIC: begin
        victim_nxt = (tail_r == slot_r) ? new_q : tail_r;
        ret_nxt    = S_SEC_ADD;
        state_nxt  = S_EV_RD;
      end
      S_SEC_ADD: begin
        cur_bits_nxt = cur_bits_r | bit_sel;
        held_nxt     = held_r + HELD_W'(1);
        sec_nxt      = sec_r + SEC_CW'(1);
        ret_nxt      = S_SEC;
        state_nxt    = S_MV_RD;
      end
      S_EV_RD: begin
        rd_addr   = victim_r;
        state_nxt = S_EV_EMIT;
      end
      S_EV_EMIT: begin
        rd_addr = victim_r;
        if (out_free) begin
          ld                  = 1'b1;
          ld_res.kind         = KIND_WB;
          ld_res.out_page     = tag_q;
          ld_res.out_mask     = bits_q;
          unl_go              = 1'b1;
          unl_s               = victim_r;
          valid_nxt[victim_r] = 1'b0;
          held_nxt            = (held_r > HELD_W'(sz)) ? held_r - HELD_W'(sz) : '0;
          need_nxt            = (need_r > sz) ? need_r - sz : 4'd0;
          if (!have_free_r || victim_r < free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = victim_r;
          end
          state_nxt = ret_r;
        end
      end
      S_MV_RD: begin
        state_nxt = (empty_r || slot_r != head_r) ? S_MV_UNL : ret_r;
      end
      S_MV_UNL: begin
        unl_go    = 1'b1;
        state_nxt = S_MV_PUSH;
      end
      S_MV_PUSH: begin
        psh_go    = 1'b1;
        state_nxt = ret_r;
      end
      S_FINAL: begin
        if (out_free) begin
          ld               = 1'b1;
          ld_res.kind      = fin_kind_r;
          ld_res.out_page  = page_r;
          ld_res.out_mask  = fin_mask_r;
          ld_res.hit_count = hits_r;
          ld_res.last      = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (unl_go) begin
      if (unl_s == head_r && unl_s == tail_r) begin
        empty_nxt = 1'b1;
      end else if (unl_s == head_r) begin
        head_nxt = old_q;
      end else if (unl_s == tail_r) begin
        tail_nxt = new_q;
      end else begin
        old_we = 1'b1;
        old_wa = new_q;
        old_wd = old_q;
        new_we = 1'b1;
        new_wa = old_q;
        new_wd = new_q;
      end
    end

    if (psh_go) begin
      if (empty_r) begin
        head_nxt  = slot_r;
        tail_nxt  = slot_r;
        empty_nxt = 1'b0;
      end else begin
        old_we   = 1'b1;
        new_we   = 1'b1;
        head_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[slot_r] <= page_r;
    end
    if (bits_we) begin
      bits_mem[slot_r] <= bits_wd;
    end
    if (old_we) begin
      old_mem[old_wa] <= old_wd;
    end
    if (new_we) begin
      new_mem[new_wa] <= new_wd;
    end
    tag_q  <= tag_mem[rd_addr];
    bits_q <= bits_mem[rd_addr];
    old_q  <= old_mem[rd_addr];
    new_q  <= new_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_r   <= 9'd256;
      valid_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
      held_r  <= '0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      held_r  <= held_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r       <= ret_nxt;
    wr_r        <= wr_nxt;
    page_r      <= page_nxt;
    req_r       <= req_nxt;
    scan_r      <= scan_nxt;
    sidx_r      <= sidx_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    have_free_r <= have_free_nxt;
    free_r      <= free_nxt;
    cur_bits_r  <= cur_bits_nxt;
    hits_r      <= hits_nxt;
    cnt_r       <= cnt_nxt;
    need_r      <= need_nxt;
    sec_r       <= sec_nxt;
    victim_r    <= victim_nxt;
    fin_kind_r  <= fin_kind_nxt;
    fin_mask_r  <= fin_mask_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  lswb_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_res    (ld_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .free      (out_free)
  );

  a_empty_held: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> held_r == '0)
    else $error("empty list holds sectors");

  a_empty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> valid_r == '0)
    else $error("valid entry outside LRU list");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> out_free)
    else $error("result loaded over pending result");

endmodule
`default_nettype wire

[verif/lru_sector_write_buffer_chk.sv]
// lru_sector_write_buffer_chk: watches the request, result and cfg ports,
// predicts the results of each accepted request and compares them in order.
// Depends on lswb_pkg.
module lru_sector_write_buffer_chk
  import lswb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  lswb_req_t  in_req,
  input  logic       out_valid,
  input  logic       out_stall,
  input  lswb_res_t  out_res,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output int         errors,
  output int         pending
);

  logic [23:0] tag [256];
  logic [7:0]  held_bits [256];
  logic [7:0]  older [256];
  logic [7:0]  newer [256];
  bit          used [256];
  logic [7:0]  head, tail;
  bit          empty;
  int          held, capacity;
  lswb_res_t   expected_q[$];

  function automatic int count8(logic [7:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) n += v[i];
    return n;
  endfunction

  task automatic put(logic [1:0] k, logic [23:0] pg, logic [7:0] m, int h, bit l);
    lswb_res_t r;
    r.kind = k;
    r.out_page = pg;
    r.out_mask = m;
    r.hit_count = 4'(h);
    r.last = l;
    expected_q.push_back(r);
  endtask

  task automatic unlink(logic [7:0] s);
    logic [7:0] o, n;
    o = older[s];
    n = newer[s];
    if (s == head && s == tail) empty = 1;
    else if (s == head) head = o;
    else if (s == tail) tail = n;
    else begin
      older[n] = o;
      newer[o] = n;
    end
  endtask

  task automatic push_head(logic [7:0] s);
    if (empty) begin
      head = s;
      tail = s;
      empty = 0;
    end else begin
      older[s] = head;
      newer[head] = s;
      head = s;
    end
  endtask

  task automatic to_head(logic [7:0] s);
    if (empty || s != head) begin
      unlink(s);
      push_head(s);
    end
  endtask

  task automatic evict(logic [7:0] v, output int sz);
    sz = count8(held_bits[v]);
    put(KIND_WB, tag[v], held_bits[v], 0, 0);
    unlink(v);
    used[v] = 0;
    held = (held > sz) ? held - sz : 0;
  endtask

  task automatic predict_request(lswb_req_t r);
    logic [23:0] pg;
    logic [7:0]  want, st, slot;
    bit          found, have_slot;
    int          hits, cnt, avail, need, sz;
    pg = r.page_number & PAGE_MASK;
    want = r.sector_mask & SECT_ALL;
    found = 0;
    slot = 0;
    hits = 0;
    for (int i = 0; i < 256; i++)
      if (!found && used[i] && tag[i] == pg) begin
        found = 1;
        slot = 8'(i);
      end
    if (!r.req_type) begin
      st = found ? held_bits[slot] : 8'd0;
      hits = count8(want & st);
      if (found && hits != 0) to_head(slot);
      put(KIND_READ, pg, want & ~st, hits, 1);
      return;
    end
    if (want == 0) begin
      put(KIND_WDONE, pg, 8'd0, 0, 1);
      return;
    end
    if (!found) begin
      cnt = count8(want);
      avail = (capacity > held) ? capacity - held : 0;
      need = (cnt > avail) ? cnt - avail : 0;
      while (need > 0 && !empty) begin
        evict(tail, sz);
        need = (need > sz) ? need - sz : 0;
      end
      have_slot = 0;
      for (int i = 0; i < 256; i++)
        if (!have_slot && !used[i]) begin
          have_slot = 1;
          slot = 8'(i);
        end
      if (!have_slot) begin
        slot = tail;
        evict(tail, sz);
      end
      used[slot] = 1;
      tag[slot] = pg;
      held_bits[slot] = want;
      push_head(slot);
      held += cnt;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (want[i]) begin
          if (held_bits[slot][i]) begin
            hits++;
            to_head(slot);
          end else begin
            if (held >= capacity && !(head == slot && tail == slot))
              evict((tail == slot) ? newer[slot] : tail, sz);
            to_head(slot);
            held_bits[slot][i] = 1'b1;
            held++;
          end
        end
      end
    end
    put(KIND_WDONE, pg, 8'd0, hits, 1);
  endtask

  always @(posedge clk) begin
    lswb_res_t e;
    if (!rst_n) begin
      for (int i = 0; i < 256; i++) used[i] = 0;
      head = 0;
      tail = 0;
      empty = 1;
      held = 0;
      capacity = 256;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) capacity = int'(cfg_wdata);
      if (in_valid && !in_stall) predict_request(in_req);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_res);
        end else begin
          e = expected_q.pop_front();
          if (e.kind != out_res.kind || e.out_page != out_res.out_page ||
              e.out_mask != out_res.out_mask || e.hit_count != out_res.hit_count ||
              e.last != out_res.last) begin
            errors++;
            $display("%0t: mismatch exp kind=%0d page=%h mask=%h hits=%0d last=%0b",
                     $time, e.kind, e.out_page, e.out_mask, e.hit_count, e.last);
            $display("%0t:          act kind=%0d page=%h mask=%h hits=%0d last=%0b",
                     $time, out_res.kind, out_res.out_page, out_res.out_mask,
                     out_res.hit_count, out_res.last);
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

[verif/lru_sector_write_buffer_tb.sv]
// lru_sector_write_buffer_tb: drives requests and capacity settings into the
// write buffer and gives the verdict. Depends on lswb_pkg, the block and
// lru_sector_write_buffer_chk.
module lru_sector_write_buffer_tb
  import lswb_pkg::*;
;

  localparam int STALL_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  lswb_req_t  in_req;
  logic       out_valid;
  logic       out_stall;
  lswb_res_t  out_res;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  int         errors, pending, quiet, burst_left;
  int         stall_mode = 0;
  int         mode_left = 0;
  logic [23:0] pool [32];

  lru_sector_write_buffer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lru_sector_write_buffer_chk i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver stall pattern: free, random, or mostly stalled, switched in runs
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(16, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("[lru_sector_write_buffer] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(bit wr, logic [23:0] pg, logic [7:0] m);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_req.req_type <= wr;
    in_req.page_number <= pg;
    in_req.sector_mask <= m;
    // in_stall only changes at the rising edge, so a low value here means
    // the next rising edge takes the request
    while (in_stall) @(negedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain_and_set(logic [8:0] cap);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_request();
    logic [23:0] pg;
    logic [7:0]  m;
    pg = ($urandom_range(0, 6) == 0) ? 24'($urandom) : pool[$urandom_range(0, 31)];
    case ($urandom_range(0, 3))
      0: m = 8'(1 << $urandom_range(0, 7));
      1: m = 8'hff;
      default: m = 8'($urandom_range(1, 255));
    endcase
    send($urandom_range(0, 1), pg, m);
  endtask

  initial begin
    int base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet = 0;
    burst_left = 0;
    pool[0] = 24'h000000;
    pool[1] = 24'hffffff;
    for (int i = 2; i < 32; i++) pool[i] = 24'($urandom);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // tiny capacity: page alone grows past capacity, capacity below held,
    // eviction running dry
    drain_and_set(9'd4);
    send(1'b0, 24'h000000, 8'hff);
    send(1'b1, 24'h000000, 8'h0f);
    send(1'b1, 24'h000000, 8'hf0);
    send(1'b0, 24'h000000, 8'h81);
    send(1'b1, 24'hffffff, 8'h01);
    send(1'b1, 24'h123456, 8'hff);
    send(1'b1, 24'h123456, 8'h00);
    send(1'b0, 24'h123456, 8'h3c);

    drain_and_set(9'd256);
    send(1'b1, 24'hffffff, 8'h80);
    send(1'b1, 24'h000000, 8'h01);
    send(1'b0, 24'hffffff, 8'hff);
    send(1'b1, 24'hffffff, 8'h7f);
    send(1'b1, 24'h000000, 8'hfe);
    send(1'b0, 24'h000000, 8'h55);
    send(1'b0, 24'h0a0a0a, 8'haa);
    for (int n = 0; n < 45; n++) random_request();

    // shrink below what is held
    drain_and_set(9'd8);
    for (int n = 0; n < 35; n++) random_request();

    // large capacity: single-sector pages fill every entry
    drain_and_set(9'd511);
    base = $urandom;
    for (int n = 0; n < 295; n++) begin
      if (n % 9 == 8) random_request();
      else send(1'b1, 24'(base + n * 7919), 8'(1 << $urandom_range(0, 7)));
    end

    drain_and_set(9'd255);
    for (int n = 0; n < 40; n++) random_request();

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("[lru_sector_write_buffer] OK");
    end else begin
      $display("[lru_sector_write_buffer] ERROR");
    end
    $finish;
  end

endmodule
